// ===== rtl/lldp_pkg.sv =====
// Package for the LLDP TLV validator: shared types and constants.
// No dependencies.
package lldp_pkg;

    localparam int DataW  = 8;
    localparam int TypeW  = 7;
    localparam int LenW   = 9;
    localparam int ValW   = 32;
    localparam int PosW   = 10;

    localparam logic [TypeW-1:0] TypeEnd      = 7'd0;
    localparam logic [TypeW-1:0] TypeChas     = 7'd1;
    localparam logic [TypeW-1:0] TypePort     = 7'd2;
    localparam logic [TypeW-1:0] TypeTtl      = 7'd3;
    localparam logic [TypeW-1:0] TypePortDesc = 7'd4;
    localparam logic [TypeW-1:0] TypeSysName  = 7'd5;
    localparam logic [TypeW-1:0] TypeSysDesc  = 7'd6;
    localparam logic [TypeW-1:0] TypeCaps     = 7'd7;
    localparam logic [TypeW-1:0] TypeMgmt     = 7'd8;
    localparam logic [TypeW-1:0] TypeOrg      = 7'd127;

    typedef struct packed {
        logic [DataW-1:0] data_byte;
        logic             last_byte;
    } t_in_beat;

    typedef struct packed {
        logic             record_kind;
        logic [TypeW-1:0] rec_type;
        logic [LenW-1:0]  rec_length;
        logic             tlv_bad;
        logic [ValW-1:0]  rec_value;
        logic             frame_bad;
        logic             missing_mandatory;
        logic             last_result;
    } t_out_beat;

    // utf8 decoder state: remaining continuation bytes and range code
    typedef struct packed {
        logic [2:0] rc;
        logic [1:0] rem;
    } t_utf8;

endpackage

// ===== rtl/lldp_if.sv =====
// Valid/ready stream interfaces for the LLDP TLV validator.
// Depends on lldp_pkg.
interface lldp_in_if import lldp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lldp_out_if import lldp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/lldp_utf8.sv =====
// One step of the UTF-8 validity decoder.
// Depends on lldp_pkg.
module lldp_utf8 import lldp_pkg::*; (
    input  t_utf8            i_state,
    input  logic [DataW-1:0] i_byte,
    output t_utf8            o_state,
    output logic             o_bad
);
    logic [7:0] lo;
    logic [7:0] hi;

    always_comb begin
        o_state = '0;
        o_bad   = 1'b0;
        lo      = 8'h80;
        hi      = 8'hbf;
        case (i_state.rc)
            3'd1:    lo = 8'ha0;
            3'd2:    hi = 8'h9f;
            3'd3:    lo = 8'h90;
            3'd4:    hi = 8'h8f;
            default: ;
        endcase
        if (i_state.rem == 2'd0) begin
            if (i_byte < 8'h80) begin
                o_state = '0;
            end else if (i_byte >= 8'hc2 && i_byte <= 8'hdf) begin
                o_state = '{rc: 3'd0, rem: 2'd1};
            end else if (i_byte == 8'he0) begin
                o_state = '{rc: 3'd1, rem: 2'd2};
            end else if (i_byte == 8'hed) begin
                o_state = '{rc: 3'd2, rem: 2'd2};
            end else if (i_byte >= 8'he1 && i_byte <= 8'hef) begin
                o_state = '{rc: 3'd0, rem: 2'd2};
            end else if (i_byte == 8'hf0) begin
                o_state = '{rc: 3'd3, rem: 2'd3};
            end else if (i_byte == 8'hf4) begin
                o_state = '{rc: 3'd4, rem: 2'd3};
            end else if (i_byte >= 8'hf1 && i_byte <= 8'hf3) begin
                o_state = '{rc: 3'd0, rem: 2'd3};
            end else begin
                o_bad = 1'b1;
            end
        end else if (i_byte < lo || i_byte > hi) begin
            o_bad = 1'b1;
        end else begin
            o_state = '{rc: 3'd0, rem: i_state.rem - 2'd1};
        end
    end
endmodule

// ===== rtl/lldp_tlv_validator_unit.sv =====
// Top level of the LLDP TLV validator: byte parser, rule checks, result queue.
// Depends on lldp_pkg, lldp_if and lldp_utf8.
//
// One LLDPDU byte enters per beat and may cause up to two result beats (a TLV
// record and a frame verdict). Each accepted byte is registered, then all
// parsing and checking runs in combinational logic that writes its results
// into a four-entry output queue. Bytes are taken every cycle while the
// queue has room for two more results, so the sustained rate is one byte per
// cycle whenever the sink keeps up; the verdict cycle after a TLV record
// drains one extra result. Results pass the input register, then the queue.
module lldp_tlv_validator_unit import lldp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lldp_in_if.sink    i_in,
    lldp_out_if.source o_out
);
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;

    // input register
    logic     r_in_vld;
    t_in_beat r_in;

    // parser state
    logic [PosW-1:0]  r_pos;
    logic [DataW-1:0] r_hdr_hi;
    logic [TypeW-1:0] r_type;
    logic [LenW-1:0]  r_len;
    logic [1:0]       r_cnt;
    logic [2:0]       r_seen;
    logic             r_shut;
    logic             r_fbad;
    logic             r_tbad;
    logic [15:0]      r_cap;
    logic [ValW-1:0]  r_acc;
    t_utf8            r_utf;
    logic             r_done;

    logic [PosW-1:0]  n_pos;
    logic [DataW-1:0] n_hdr_hi;
    logic [TypeW-1:0] n_type;
    logic [LenW-1:0]  n_len;
    logic [1:0]       n_cnt;
    logic [2:0]       n_seen;
    logic             n_shut;
    logic             n_fbad;
    logic             n_tbad;
    logic [15:0]      n_cap;
    logic [ValW-1:0]  n_acc;
    t_utf8            n_utf;
    logic             n_done;

    // output queue
    t_out_beat        r_q [QDepth];
    logic [QPtrW-1:0] r_wp;
    logic [QPtrW-1:0] r_rp;
    logic [QPtrW:0]   r_qcnt;

    t_out_beat res0;
    t_out_beat res1;
    logic [1:0] nres;

    t_utf8 utf_nx;
    logic  utf_bad;

    logic [DataW-1:0] b;
    logic             last;
    logic [LenW-1:0]  idx;
    logic [15:0]      hw;
    logic [9:0]       a;
    logic [10:0]      mlen;
    logic             complete;
    logic             end_frame;
    logic             bad;
    logic [ValW-1:0]  val;
    logic [TypeW-1:0] expect_t;
    logic [7:0]       sub;
    logic [7:0]       fam;
    logic             miss;
    logic             fbad_rec;
    logic             deq;

    lldp_utf8 u_utf8 (
        .i_state (r_utf),
        .i_byte  (r_in.data_byte),
        .o_state (utf_nx),
        .o_bad   (utf_bad)
    );

    // accept when queue can absorb two results even with one in flight
    assign i_in.ready    = (r_qcnt - (QPtrW+1)'(deq) + (r_in_vld ? 3'd2 : 3'd0))
                           <= 3'(QDepth - 2);
    assign o_out.valid   = r_qcnt != '0;
    assign o_out.payload = r_q[r_rp];
    assign deq           = o_out.valid && o_out.ready;

    // parse and check one byte
    always_comb begin
        b        = r_in.data_byte;
        last     = r_in.last_byte;
        n_pos    = r_pos;   n_hdr_hi = r_hdr_hi; n_type = r_type; n_len = r_len;
        n_cnt    = r_cnt;   n_seen   = r_seen;   n_shut = r_shut; n_fbad = r_fbad;
        n_tbad   = r_tbad;  n_cap    = r_cap;    n_acc  = r_acc;  n_utf  = r_utf;
        n_done   = r_done;
        res0     = '0;
        res1     = '0;
        nres     = 2'd0;
        complete = 1'b0;
        end_frame = 1'b0;
        idx      = r_pos[LenW-1:0] - LenW'(2);
        hw       = {r_hdr_hi, b};
        a        = {2'b0, r_cap[7:0]};
        mlen     = '0;
        bad      = 1'b0;
        val      = '0;
        expect_t = '0;
        sub      = '0;
        fam      = '0;
        miss     = 1'b0;
        fbad_rec = 1'b0;

        if (r_in_vld) begin
            if (r_done) begin
                if (last) begin
                    n_pos = '0; n_hdr_hi = '0; n_type = '0; n_len = '0; n_cnt = '0;
                    n_seen = '0; n_shut = 1'b0; n_fbad = 1'b0; n_tbad = 1'b0;
                    n_cap = '0; n_acc = '0; n_utf = '0; n_done = 1'b0;
                end
            end else begin
                if (r_pos == '0) begin
                    n_hdr_hi = b;
                    n_pos    = PosW'(1);
                    if (last) begin
                        n_fbad    = 1'b1;
                        end_frame = 1'b1;
                    end
                end else begin
                    if (r_pos == PosW'(1)) begin
                        n_type   = hw[15:9];
                        n_len    = hw[8:0];
                        n_tbad   = 1'b0;
                        n_cap    = '0;
                        n_acc    = '0;
                        n_utf    = '0;
                        n_pos    = PosW'(2);
                        complete = hw[8:0] == '0;
                    end else begin
                        // body byte, idx fits since pos<=len+1
                        if (r_type == TypeChas || r_type == TypePort) begin
                            if (idx == '0) n_cap[7:0] = b;
                            else if (idx == LenW'(1)) n_cap[15:8] = b;
                        end else if (r_type == TypeTtl || r_type == TypeCaps
                                     || r_type == TypeOrg) begin
                            if (idx < LenW'(4)) n_acc = {r_acc[23:0], b};
                        end else if (r_type >= TypePortDesc && r_type <= TypeSysDesc) begin
                            n_utf = utf_nx;
                            if (utf_bad) n_tbad = 1'b1;
                        end else if (r_type == TypeMgmt) begin
                            if (idx == '0) begin
                                n_cap = {8'd0, b};
                            end else if ({1'b0, idx} >= a + 10'd2
                                         && {1'b0, idx} <= a + 10'd5) begin
                                n_acc = {r_acc[23:0], b};
                            end else if ({1'b0, idx} == a + 10'd6) begin
                                n_cap[15:8] = b;
                            end
                        end
                        n_pos    = r_pos + PosW'(1);
                        complete = ({1'b0, idx} + 10'd1) >= {1'b0, r_len};
                    end

                    if (complete) begin
                        // finish the TLV using post-header type/length
                        bad = (r_pos == PosW'(1)) ? 1'b0 : n_tbad;
                        unique case (r_cnt)
                            2'd0:    expect_t = TypeChas;
                            2'd1:    expect_t = TypePort;
                            2'd2:    expect_t = TypeTtl;
                            default: expect_t = n_type;
                        endcase
                        if (n_type != expect_t) bad = 1'b1;
                        if (n_type >= TypeChas && n_type <= TypeTtl
                            && r_seen[n_type[1:0] - 2'd1])
                            bad = 1'b1;
                        if (r_shut && r_cnt == 2'd3 && n_type != TypeEnd) bad = 1'b1;
                        sub  = n_cap[7:0];
                        fam  = n_cap[15:8];
                        a    = {2'b0, n_cap[7:0]};
                        mlen = {1'b0, a} + 11'd7 + {3'b0, fam};
                        case (n_type)
                            TypeEnd: if (n_len != '0) bad = 1'b1;
                            TypeChas, TypePort: begin
                                if (n_len < 9'd2 || n_len > 9'd256) begin
                                    bad = 1'b1;
                                end else begin
                                    if (((n_type == TypeChas && sub == 8'd4)
                                         || (n_type == TypePort && sub == 8'd3))
                                        && n_len != 9'd7)
                                        bad = 1'b1;
                                    if ((n_type == TypeChas && sub == 8'd5)
                                        || (n_type == TypePort && sub == 8'd4)) begin
                                        if (n_len < 9'd3) bad = 1'b1;
                                        else if ((fam == 8'd1 && n_len != 9'd6)
                                                 || (fam == 8'd2 && n_len != 9'd18))
                                            bad = 1'b1;
                                    end
                                end
                            end
                            TypeTtl: begin
                                if (n_len != 9'd2) begin
                                    bad = 1'b1;
                                end else begin
                                    val    = {16'd0, n_acc[15:0]};
                                    n_shut = n_acc[15:0] == '0;
                                end
                            end
                            TypePortDesc, TypeSysName, TypeSysDesc:
                                if (n_utf.rem != '0) bad = 1'b1;
                            TypeCaps: begin
                                if (n_len != 9'd4) bad = 1'b1;
                                else val = n_acc;
                            end
                            TypeMgmt: begin
                                if (n_len < 9'd8 || a == '0
                                    || a + 10'd7 > {1'b0, n_len}) begin
                                    bad = 1'b1;
                                end else begin
                                    if (mlen != {2'b0, n_len}) bad = 1'b1;
                                    if (mlen <= {2'b0, n_len}) val = n_acc;
                                end
                            end
                            TypeOrg: begin
                                if (n_len < 9'd4) bad = 1'b1;
                                else val = n_acc;
                            end
                            default: ;
                        endcase
                        if (n_type >= TypeChas && n_type <= TypeTtl)
                            n_seen[n_type[1:0] - 2'd1] = 1'b1;
                        if (r_cnt != 2'd3) n_cnt = r_cnt + 2'd1;
                        fbad_rec = r_fbad || bad;
                        n_fbad   = fbad_rec;
                        n_pos    = '0;
                        res0 = '{record_kind: 1'b0, rec_type: n_type, rec_length: n_len,
                                 tlv_bad: bad, rec_value: val, frame_bad: fbad_rec,
                                 missing_mandatory: 1'b0, last_result: 1'b0};
                        nres = 2'd1;
                        if (n_type == TypeEnd || last) end_frame = 1'b1;
                    end else if (last) begin
                        n_fbad = 1'b1;
                        res0 = '{record_kind: 1'b0, rec_type: n_type, rec_length: n_len,
                                 tlv_bad: 1'b1, rec_value: '0, frame_bad: 1'b1,
                                 missing_mandatory: 1'b0, last_result: 1'b0};
                        nres = 2'd1;
                        end_frame = 1'b1;
                    end
                end

                if (end_frame) begin
                    miss = n_seen != 3'b111;
                    res1 = '{record_kind: 1'b1, rec_type: '0, rec_length: '0,
                             tlv_bad: 1'b0, rec_value: '0, frame_bad: n_fbad || miss,
                             missing_mandatory: miss, last_result: 1'b1};
                    if (nres == 2'd0) res0 = res1;
                    nres = nres + 2'd1;
                    if (last) begin
                        n_pos = '0; n_hdr_hi = '0; n_type = '0; n_len = '0; n_cnt = '0;
                        n_seen = '0; n_shut = 1'b0; n_fbad = 1'b0; n_tbad = 1'b0;
                        n_cap = '0; n_acc = '0; n_utf = '0; n_done = 1'b0;
                    end else begin
                        n_done = 1'b1;
                    end
                end else if (nres == 2'd1) begin
                    res0.last_result = 1'b1;
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_in.valid && i_in.ready;
        end
        r_in <= i_in.payload;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_hdr_hi <= '0; r_type <= '0; r_len <= '0; r_cnt <= '0;
            r_seen <= '0; r_shut <= 1'b0; r_fbad <= 1'b0; r_tbad <= 1'b0;
            r_cap <= '0; r_acc <= '0; r_utf <= '0; r_done <= 1'b0;
        end else begin
            r_pos <= n_pos; r_hdr_hi <= n_hdr_hi; r_type <= n_type; r_len <= n_len;
            r_cnt <= n_cnt; r_seen <= n_seen; r_shut <= n_shut; r_fbad <= n_fbad;
            r_tbad <= n_tbad; r_cap <= n_cap; r_acc <= n_acc; r_utf <= n_utf;
            r_done <= n_done;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            r_wp   <= r_wp + QPtrW'(nres);
            r_rp   <= r_rp + QPtrW'(deq);
            r_qcnt <= r_qcnt + (QPtrW+1)'(nres) - (QPtrW+1)'(deq);
        end
        if (nres != 2'd0) r_q[r_wp] <= res0;
        if (nres == 2'd2) r_q[r_wp + QPtrW'(1)] <= res1;
    end

endmodule

// ===== tb/tb_lldp_tlv_validator_unit.sv =====
// Testbench for lldp_tlv_validator_unit: directed LLDPDU bytes, then random frames.
// Results are checked against an in-bench model of the TLV rules.
// Depends on lldp_pkg, lldp_if and the validator RTL.
`timescale 1ns / 1ps

module tb_lldp_tlv_validator_unit;
    import lldp_pkg::*;

    localparam int RandomBytes = 1650;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_out_beat  result;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    lldp_in_if  in_if ();
    lldp_out_if out_if ();

    lldp_tlv_validator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // expected result beats, oldest first
    t_out_beat pending_results[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        bytes_sent = 0;

    // parser state of the model
    logic [PosW-1:0]  pos;
    logic [7:0]       hdr_hi;
    logic [TypeW-1:0] cur_type;
    logic [LenW-1:0]  cur_len;
    logic [1:0]       tlv_cnt;
    logic [2:0]       seen;
    logic             shut_seen, frame_bad_r, tlv_bad_r, frame_done;
    logic [15:0]      cap;
    logic [31:0]      acc;
    t_utf8            utf;

    function automatic void clear_frame();
        pos = '0; hdr_hi = '0; cur_type = '0; cur_len = '0; tlv_cnt = '0;
        seen = '0; shut_seen = 1'b0; frame_bad_r = 1'b0; tlv_bad_r = 1'b0;
        cap = '0; acc = '0; utf = '0; frame_done = 1'b0;
    endfunction

    function automatic void add_result(logic kind, logic [TypeW-1:0] t, logic [LenW-1:0] l,
                                       logic bad, logic [31:0] v, logic fb, logic miss,
                                       ref t_out_beat q[$]);
        t_out_beat r;
        r = '{kind, t, l, bad, v, fb, miss, 1'b0};
        q.push_back(r);
    endfunction

    function automatic void utf8_byte(logic [7:0] b);
        logic [7:0] lo, hi;
        lo = 8'h80;
        hi = 8'hbf;
        if (utf.rem == 2'd0) begin
            if (b < 8'h80) return;
            if (b >= 8'hc2 && b <= 8'hdf) utf = '{3'd0, 2'd1};
            else if (b == 8'he0) utf = '{3'd1, 2'd2};
            else if (b == 8'hed) utf = '{3'd2, 2'd2};
            else if (b >= 8'he1 && b <= 8'hef) utf = '{3'd0, 2'd2};
            else if (b == 8'hf0) utf = '{3'd3, 2'd3};
            else if (b == 8'hf4) utf = '{3'd4, 2'd3};
            else if (b >= 8'hf1 && b <= 8'hf3) utf = '{3'd0, 2'd3};
            else begin
                tlv_bad_r = 1'b1;
                utf = '0;
            end
            return;
        end
        case (utf.rc)
            3'd1: lo = 8'ha0;
            3'd2: hi = 8'h9f;
            3'd3: lo = 8'h90;
            3'd4: hi = 8'h8f;
            default: ;
        endcase
        if (b < lo || b > hi) begin
            tlv_bad_r = 1'b1;
            utf = '0;
        end else begin
            utf = '{3'd0, utf.rem - 2'd1};
        end
    endfunction

    function automatic void body_byte(logic [7:0] b, int idx);
        int a;
        if (cur_type == TypeChas || cur_type == TypePort) begin
            if (idx == 0) cap[7:0] = b;
            else if (idx == 1) cap[15:8] = b;
        end else if (cur_type == TypeTtl || cur_type == TypeCaps || cur_type == TypeOrg) begin
            if (idx < 4) acc = {acc[23:0], b};
        end else if (cur_type >= TypePortDesc && cur_type <= TypeSysDesc) begin
            utf8_byte(b);
        end else if (cur_type == TypeMgmt) begin
            if (idx == 0) begin
                cap = {8'd0, b};
            end else begin
                a = int'(cap[7:0]);
                if (idx >= 2 + a && idx <= 5 + a) acc = {acc[23:0], b};
                else if (idx == 6 + a) cap[15:8] = b;
            end
        end
    endfunction

    // closes the current TLV and queues its record
    function automatic void close_tlv(ref t_out_beat q[$]);
        int          t, len, sub, fam, a, o, want;
        logic        bad;
        logic [31:0] v;
        t = int'(cur_type); len = int'(cur_len); v = '0; bad = tlv_bad_r;
        sub = int'(cap[7:0]); fam = int'(cap[15:8]);
        want = (tlv_cnt == 2'd0) ? 1 : (tlv_cnt == 2'd1) ? 2 : (tlv_cnt == 2'd2) ? 3 : t;
        if (t != want) bad = 1'b1;
        if ((t >= 1 && t <= 3 && seen[t-1]) || (shut_seen && tlv_cnt == 2'd3 && t != 0))
            bad = 1'b1;
        case (t)
            TypeEnd: if (len != 0) bad = 1'b1;
            TypeChas, TypePort: begin
                if (len < 2 || len > 256) begin
                    bad = 1'b1;
                end else begin
                    if (((t == TypeChas && sub == 4) || (t == TypePort && sub == 3)) && len != 7)
                        bad = 1'b1;
                    if ((t == TypeChas && sub == 5) || (t == TypePort && sub == 4)) begin
                        if (len < 3) bad = 1'b1;
                        else if ((fam == 1 && len != 6) || (fam == 2 && len != 18)) bad = 1'b1;
                    end
                end
            end
            TypeTtl: begin
                if (len != 2) bad = 1'b1;
                else begin
                    v = {16'd0, acc[15:0]};
                    shut_seen = (acc[15:0] == 16'd0);
                end
            end
            TypePortDesc, TypeSysName, TypeSysDesc: if (utf.rem != 2'd0) bad = 1'b1;
            TypeCaps: if (len != 4) bad = 1'b1; else v = acc;
            TypeMgmt: begin
                a = int'(cap[7:0]); o = int'(cap[15:8]);
                if (len < 8 || a == 0 || a + 7 > len) bad = 1'b1;
                else begin
                    if (a + 7 + o != len) bad = 1'b1;
                    if (a + 7 + o <= len) v = acc;
                end
            end
            TypeOrg: if (len < 4) bad = 1'b1; else v = acc;
            default: ;
        endcase
        if (t >= 1 && t <= 3) seen[t-1] = 1'b1;
        if (tlv_cnt < 2'd3) tlv_cnt++;
        if (bad) frame_bad_r = 1'b1;
        add_result(1'b0, TypeW'(t), LenW'(len), bad, v, frame_bad_r, 1'b0, q);
        pos = '0;
    endfunction

    // model of one accepted byte; appends its results to q
    function automatic void predict_byte(logic [7:0] b, logic last, ref t_out_beat q[$]);
        int   n0, idx;
        logic end_frame, complete, miss;
        n0 = q.size(); end_frame = 1'b0; complete = 1'b0;
        if (frame_done) begin
            if (last) clear_frame();
            return;
        end
        if (pos == '0) begin
            hdr_hi = b;
            pos = PosW'(1);
            if (last) begin
                frame_bad_r = 1'b1;
                end_frame = 1'b1;
            end
        end else begin
            if (pos == PosW'(1)) begin
                {cur_type, cur_len} = {hdr_hi, b};
                tlv_bad_r = 1'b0; cap = '0; acc = '0; utf = '0;
                pos = PosW'(2);
                complete = (cur_len == '0);
            end else begin
                idx = int'(pos) - 2;
                body_byte(b, idx);
                pos = pos + PosW'(1);
                complete = (idx + 1 >= int'(cur_len));
            end
            if (complete) begin
                close_tlv(q);
                if (cur_type == TypeEnd || last) end_frame = 1'b1;
            end else if (last) begin
                frame_bad_r = 1'b1;
                add_result(1'b0, cur_type, cur_len, 1'b1, '0, 1'b1, 1'b0, q);
                end_frame = 1'b1;
            end
        end
        if (end_frame) begin
            miss = (seen != 3'b111);
            add_result(1'b1, '0, '0, 1'b0, '0, frame_bad_r | miss, miss, q);
            if (last) clear_frame();
            else frame_done = 1'b1;
        end
        if (q.size() > n0) q[q.size()-1].last_result = 1'b1;
    endfunction

    // sink side: random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, out_if.payload);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.payload !== want) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, want, out_if.payload);
                    errors++;
                end
            end
        end
    end

    // drives one byte and waits for its beat; typed rows carry their own result
    task automatic send_byte(logic [7:0] b, logic last, logic typed, t_out_beat res);
        t_out_beat scratch[$];
        in_if.valid <= 1'b1;
        in_if.payload <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (!in_if.ready);
        if (typed) begin
            predict_byte(b, last, scratch);
            pending_results.push_back(res);
        end else begin
            predict_byte(b, last, pending_results);
        end
        bytes_sent++;
        // idle cycles, each taken with the phase's probability
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // frame builder for the random part
    logic [7:0] frame_q[$];

    task automatic put_tlv(int t, logic [7:0] body[$]);
        int len;
        len = body.size();
        frame_q.push_back({t[6:0], len[8]});
        frame_q.push_back(len[7:0]);
        foreach (body[i]) frame_q.push_back(body[i]);
    endtask

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    task automatic put_id(int t, int mac_sub, int addr_sub);
        logic [7:0] body[$];
        int         kind;
        kind = $urandom_range(5);
        if (kind == 0) begin
            body.push_back(8'(mac_sub));
            repeat (6) body.push_back(rnd8());
        end else if (kind == 1) begin
            body.push_back(8'(addr_sub));
            body.push_back(8'($urandom_range(1, 2)));
            repeat (body[1] == 8'd1 ? 4 : 16) body.push_back(rnd8());
            if ($urandom_range(3) == 0) body.push_back(rnd8());
        end else begin
            repeat ($urandom_range(1, 12)) body.push_back(rnd8());
            if ($urandom_range(3) == 0) body[0] = 8'($urandom_range(7));
        end
        put_tlv(t, body);
    endtask

    task automatic put_text();
        logic [7:0] body[$];
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(7))
                0: body.push_back(8'($urandom_range(0, 127)));
                1: begin
                    body.push_back(8'($urandom_range(8'hc2, 8'hdf)));
                    body.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
                2: begin
                    body.push_back(8'he0);
                    body.push_back(8'($urandom_range(8'ha0, 8'hbf)));
                    body.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
                3: begin
                    body.push_back($urandom_range(0, 1) ? 8'hed : 8'he5);
                    body.push_back(8'($urandom_range(8'h80, 8'h9f)));
                    body.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
                4: begin
                    body.push_back(8'hf0);
                    body.push_back(8'($urandom_range(8'h90, 8'hbf)));
                    repeat (2) body.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
                5: begin
                    body.push_back($urandom_range(0, 1) ? 8'hf4 : 8'hf2);
                    repeat (3) body.push_back(8'($urandom_range(8'h80, 8'h8f)));
                end
                6: body.push_back(rnd8());
                default: body.push_back(8'($urandom_range(8'h80, 8'hff)));
            endcase
        end
        put_tlv($urandom_range(int'(TypePortDesc), int'(TypeSysDesc)), body);
    endtask

    task automatic put_mgmt();
        logic [7:0] body[$];
        int         a, o;
        a = $urandom_range(1, 8);
        o = $urandom_range(0, 4);
        body.push_back(8'(a));
        repeat (a) body.push_back(rnd8());
        repeat (5) body.push_back(rnd8());
        body.push_back(8'(o));
        repeat (o) body.push_back(rnd8());
        if ($urandom_range(5) == 0) body.push_back(rnd8());
        if ($urandom_range(7) == 0) body[0] = rnd8();
        put_tlv(int'(TypeMgmt), body);
    endtask

    task automatic build_frame();
        logic [7:0] body[$];
        int         r, cut;
        frame_q.delete();
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 20)) frame_q.push_back(rnd8());
            return;
        end
        put_id(int'(TypeChas), 4, 5);
        put_id(int'(TypePort), 3, 4);
        body.delete();
        body.push_back(rnd8());
        body.push_back(rnd8());
        if ($urandom_range(9) == 0) body = '{8'h00, 8'h00};
        put_tlv(int'(TypeTtl), body);
        repeat ($urandom_range(0, 3)) begin
            body.delete();
            case ($urandom_range(4))
                0: put_text();
                1: begin
                    repeat (4) body.push_back(rnd8());
                    put_tlv(int'(TypeCaps), body);
                end
                2: put_mgmt();
                3: begin
                    repeat ($urandom_range(39) == 0 ? $urandom_range(300, 511)
                                                    : $urandom_range(4, 10))
                        body.push_back(rnd8());
                    put_tlv(int'(TypeOrg), body);
                end
                default: begin
                    repeat ($urandom_range(0, 5)) body.push_back(rnd8());
                    put_tlv($urandom_range(9, 126), body);
                end
            endcase
        end
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        r = $urandom_range(9);
        if (r == 0) begin
            frame_q[$urandom_range(frame_q.size() - 1)] = rnd8();
        end else if (r == 1) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end else if (r == 2) begin
            repeat ($urandom_range(1, 5)) frame_q.push_back(rnd8());
        end
    endtask

    // directed rows: partial header, short frame, shutdown, trailing bytes, truncation
    t_row rows[] = '{
        '{8'h02, 1'b1, 1'b1, '{1'b1, 7'd0, 9'd0, 1'b0, 32'd0, 1'b1, 1'b1, 1'b1}},
        '{8'h02, 1'b0, 1'b0, '0}, '{8'h02, 1'b0, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h04, 1'b0, 1'b0, '0}, '{8'h02, 1'b0, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0}, '{8'h42, 1'b0, 1'b0, '0},
        '{8'h06, 1'b0, 1'b0, '0}, '{8'h02, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h0e, 1'b0, 1'b0, '0}, '{8'h04, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
        '{8'h7f, 1'b1, 1'b0, '0}
    };

    initial begin
        int phase;
        clear_frame();
        in_if.valid = 1'b0;
        in_if.payload = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_byte(rows[i].data, rows[i].last, rows[i].typed, rows[i].result);

        for (phase = 0; phase < 5; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin send_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            while (bytes_sent < (phase + 1) * RandomBytes / 5 + rows.size()) begin
                build_frame();
                foreach (frame_q[i])
                    send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
            end
            // hold the sender until the block has drained
            in_if.valid <= 1'b0;
            @(posedge i_clk);
            while (pending_results.size() != 0) @(posedge i_clk);
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lldp_pkg.sv
rtl/lldp_if.sv
rtl/lldp_utf8.sv
rtl/lldp_tlv_validator_unit.sv
tb/tb_lldp_tlv_validator_unit.sv
